>>> rtl/core/aed_pkg.sv
// shared types and constants for the archive entry deframer
`timescale 1ns / 1ps

package aed_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] MAGIC_WORD = 32'h4152_4348;
  localparam logic [31:0] MAGIC_SWAP = 32'h4843_5241;
  localparam logic [7:0]  METHOD_LAST = 8'h03;

  // result kinds
  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_NAME     = 3'd1;
  localparam logic [2:0] KIND_METADATA = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd3;
  localparam logic [2:0] KIND_ERROR    = 3'd4;
  localparam logic [2:0] KIND_END      = 3'd5;

  // error and end status codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MAGIC     = 3'd1;
  localparam logic [2:0] ERR_SMALL     = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED = 3'd3;
  localparam logic [2:0] ERR_METHOD    = 3'd4;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_VERSION,
    PH_NAMELEN,
    PH_NAME,
    PH_ORIG,
    PH_PROC,
    PH_METHOD,
    PH_PAYLOAD,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  byte_value;
    logic [63:0] original_size;
    logic [63:0] processed_size;
    logic [1:0]  method_code;
    logic [2:0]  error_code;
    logic        run_last;
  } out_beat_t;

  // one queue entry: an optional data result and an optional end result
  typedef struct packed {
    logic      has_data;
    out_beat_t data;
    logic      has_end;
    logic [2:0] end_status;
  } job_t;

endpackage

>>> rtl/core/aed_front.sv
// front end: accepts archive bytes, runs the parse state machine, queues results
`timescale 1ns / 1ps

module aed_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  aed_pkg::in_beat_t byte_beat,
  input  logic              queue_full,
  output logic              push,
  output aed_pkg::job_t     job
);

  aed_pkg::phase_t phase, phase_parse, phase_next;
  logic [63:0] bytes_left, left_parse, left_next;
  logic [63:0] assembly, asm_parse, asm_next;
  logic [63:0] saved_orig, saved_parse, saved_next;
  logic        big_endian, be_parse, be_next;
  logic        failed, failed_parse, failed_next;

  logic        accept;
  logic [7:0]  b;
  logic        fin;
  logic        last;
  logic        magic_ok;
  logic [63:0] take4;
  logic [63:0] take8;
  logic        has_data;
  logic [2:0]  status;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;
  assign b          = byte_beat.data_byte;
  assign fin        = byte_beat.final_byte;
  assign last       = bytes_left <= 64'd1;
  assign magic_ok   = (assembly[31:0] == aed_pkg::MAGIC_WORD) ||
                      (assembly[31:0] == aed_pkg::MAGIC_SWAP);

  // field assembly in the latched byte order
  assign take4 = big_endian ? {assembly[55:0], b} : {32'd0, b, assembly[31:8]};
  assign take8 = big_endian ? {assembly[55:0], b} : {b, assembly[63:8]};

  // next state of the parser
  always_comb begin
    phase_parse  = phase;
    left_parse   = bytes_left;
    asm_parse    = assembly;
    saved_parse  = saved_orig;
    be_parse     = big_endian;
    failed_parse = failed;
    unique case (phase)
      aed_pkg::PH_MAGIC: begin
        asm_parse = {32'd0, assembly[23:0], b};
        if (last) phase_parse = aed_pkg::PH_VERSION;
        else      left_parse  = bytes_left - 64'd1;
      end
      aed_pkg::PH_VERSION: begin
        if (magic_ok) begin
          be_parse    = (assembly[31:0] == aed_pkg::MAGIC_WORD);
          phase_parse = aed_pkg::PH_NAMELEN;
          left_parse  = 64'd4;
          asm_parse   = '0;
        end else begin
          failed_parse = 1'b1;
          phase_parse  = aed_pkg::PH_SKIP;
        end
      end
      aed_pkg::PH_NAMELEN: begin
        asm_parse = take4;
        if (!last) begin
          left_parse = bytes_left - 64'd1;
        end else if (take4 == 64'd0) begin
          phase_parse = aed_pkg::PH_ORIG;
          left_parse  = 64'd8;
          asm_parse   = '0;
        end else begin
          phase_parse = aed_pkg::PH_NAME;
          left_parse  = take4;
          asm_parse   = '0;
        end
      end
      aed_pkg::PH_NAME: begin
        if (last) begin
          phase_parse = aed_pkg::PH_ORIG;
          left_parse  = 64'd8;
          asm_parse   = '0;
        end else begin
          left_parse = bytes_left - 64'd1;
        end
      end
      aed_pkg::PH_ORIG: begin
        asm_parse = take8;
        if (!last) begin
          left_parse = bytes_left - 64'd1;
        end else begin
          saved_parse = take8;
          phase_parse = aed_pkg::PH_PROC;
          left_parse  = 64'd8;
          asm_parse   = '0;
        end
      end
      aed_pkg::PH_PROC: begin
        asm_parse = take8;
        if (!last) begin
          left_parse = bytes_left - 64'd1;
        end else begin
          phase_parse = aed_pkg::PH_METHOD;
          left_parse  = 64'd1;
        end
      end
      aed_pkg::PH_METHOD: begin
        asm_parse = '0;
        if (b > aed_pkg::METHOD_LAST || assembly == 64'd0) begin
          phase_parse = aed_pkg::PH_NAMELEN;
          left_parse  = 64'd4;
        end else begin
          phase_parse = aed_pkg::PH_PAYLOAD;
          left_parse  = assembly;
        end
      end
      aed_pkg::PH_PAYLOAD: begin
        if (last) begin
          phase_parse = aed_pkg::PH_NAMELEN;
          left_parse  = 64'd4;
          asm_parse   = '0;
        end else begin
          left_parse = bytes_left - 64'd1;
        end
      end
      default: begin
      end
    endcase
    // final byte returns the parser to its reset state
    if (fin) begin
      phase_next  = aed_pkg::PH_MAGIC;
      left_next   = 64'd4;
      asm_next    = '0;
      saved_next  = '0;
      be_next     = 1'b1;
      failed_next = 1'b0;
    end else begin
      phase_next  = phase_parse;
      left_next   = left_parse;
      asm_next    = asm_parse;
      saved_next  = saved_parse;
      be_next     = be_parse;
      failed_next = failed_parse;
    end
  end

  // results caused by this byte
  always_comb begin
    has_data = 1'b0;
    job      = '0;
    unique case (phase)
      aed_pkg::PH_VERSION: begin
        has_data                = magic_ok;
        job.data.result_kind    = aed_pkg::KIND_HEADER;
        job.data.byte_value     = b;
      end
      aed_pkg::PH_NAME: begin
        has_data                = 1'b1;
        job.data.result_kind    = aed_pkg::KIND_NAME;
        job.data.byte_value     = b;
      end
      aed_pkg::PH_METHOD: begin
        has_data = 1'b1;
        if (b > aed_pkg::METHOD_LAST) begin
          job.data.result_kind  = aed_pkg::KIND_ERROR;
          job.data.error_code   = aed_pkg::ERR_METHOD;
        end else begin
          job.data.result_kind    = aed_pkg::KIND_METADATA;
          job.data.original_size  = saved_orig;
          job.data.processed_size = assembly;
          job.data.method_code    = b[1:0];
        end
      end
      aed_pkg::PH_PAYLOAD: begin
        has_data                = 1'b1;
        job.data.result_kind    = aed_pkg::KIND_PAYLOAD;
        job.data.byte_value     = b;
      end
      default: begin
      end
    endcase

    if (phase_parse == aed_pkg::PH_MAGIC || phase_parse == aed_pkg::PH_VERSION) begin
      status = aed_pkg::ERR_SMALL;
    end else if (failed_parse || phase_parse == aed_pkg::PH_SKIP) begin
      status = aed_pkg::ERR_MAGIC;
    end else if (phase_parse == aed_pkg::PH_NAMELEN && left_parse == 64'd4) begin
      status = aed_pkg::ERR_NONE;
    end else begin
      status = aed_pkg::ERR_TRUNCATED;
    end

    job.has_data   = has_data;
    job.has_end    = fin;
    job.end_status = status;
    push           = accept && (has_data || fin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= aed_pkg::PH_MAGIC;
      bytes_left <= 64'd4;
      assembly   <= '0;
      saved_orig <= '0;
      big_endian <= 1'b1;
      failed     <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      bytes_left <= left_next;
      assembly   <= asm_next;
      saved_orig <= saved_next;
      big_endian <= be_next;
      failed     <= failed_next;
    end
  end

endmodule

>>> rtl/core/aed_queue.sv
// short result queue between the parser and the output stage
`timescale 1ns / 1ps

module aed_queue #(
  parameter int DEPTH = aed_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  aed_pkg::job_t push_job,
  input  logic          pop,
  output aed_pkg::job_t head,
  output logic          empty,
  output logic          full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  aed_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_FULL);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/core/aed_back.sv
// back end: turns queue entries into result beats behind an output register
`timescale 1ns / 1ps

module aed_back (
  input  logic               clk,
  input  logic               rst,
  input  aed_pkg::job_t      head,
  input  logic               empty,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_ready,
  output aed_pkg::out_beat_t result_beat
);

  logic               data_sent;
  logic               load;
  logic               send_data;
  aed_pkg::out_beat_t beat_next;

  assign load      = !result_valid || result_ready;
  assign send_data = head.has_data && !data_sent;
  // the entry leaves once its last beat is loaded
  assign pop       = load && !empty && !(send_data && head.has_end);

  always_comb begin
    beat_next = '0;
    if (send_data) begin
      beat_next          = head.data;
      beat_next.run_last = !head.has_end;
    end else begin
      beat_next.result_kind = aed_pkg::KIND_END;
      beat_next.error_code  = head.end_status;
      beat_next.run_last    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      result_beat <= beat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      data_sent    <= 1'b0;
    end else if (load) begin
      result_valid <= !empty;
      if (!empty) data_sent <= send_data && head.has_end;
    end
  end

endmodule

>>> rtl/core/archive_entry_deframer_top.sv
// top level of the archive entry deframer
`timescale 1ns / 1ps

// channel   direction  handshake                   payload
// byte      in         byte_valid / byte_ready     aed_pkg::in_beat_t  byte_beat
// result    out        result_valid / result_ready aed_pkg::out_beat_t result_beat
//
// one archive byte is taken per cycle unless the queue is full; a byte gives zero,
// one or two result beats: the final byte of the archive gives two beats when it
// also carries a data result, both sent from one queue entry while the queue absorbs
// the difference; a result beat passes the queue write, then the output register
// synchronous reset returns the parser to the magic phase and empties the queue
// byte_ready drops only when the queue is full; result stalls back up into it

module archive_entry_deframer_top #(
  parameter int QUEUE_DEPTH = aed_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  aed_pkg::in_beat_t  byte_beat,
  output logic               result_valid,
  input  logic               result_ready,
  output aed_pkg::out_beat_t result_beat
);

  // queue entries from the parser
  aed_pkg::job_t push_job;
  aed_pkg::job_t head;
  logic          push;
  logic          pop;
  logic          empty;
  logic          full;

  // parser: magic, version, entry fields, end status
  aed_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_beat  (byte_beat),
    .queue_full (full),
    .push       (push),
    .job        (push_job)
  );

  // decouples parsing from the output handshake
  aed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // data beat first, then the archive end beat when present
  aed_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_beat  (result_beat)
  );

endmodule

>>> rtl/core/aed_checker.sv
// port-level checks for the archive entry deframer
`timescale 1ns / 1ps

module aed_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_ready,
  input aed_pkg::out_beat_t result_beat
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_beat))
    else $error("result beat changed while stalled");

  // archive end is always the last beat of its byte
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_beat.result_kind == aed_pkg::KIND_END |-> result_beat.run_last)
    else $error("archive end beat without run_last");

  // byte-carrying beats leave the size and error fields clear
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_beat.result_kind == aed_pkg::KIND_NAME ||
                     result_beat.result_kind == aed_pkg::KIND_PAYLOAD) |->
      result_beat.original_size == 64'd0 && result_beat.processed_size == 64'd0 &&
      result_beat.error_code == aed_pkg::ERR_NONE)
    else $error("stray fields on a byte beat");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind archive_entry_deframer_top aed_checker u_aed_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_beat  (result_beat)
);

>>> dv/archive_entry_deframer_top_test.sv
// self-checking testbench for the archive entry deframer
`timescale 1ns / 1ps

module archive_entry_deframer_top_test;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int NOISY_BEATS  = 240;
  localparam int QUIET_BEATS  = 60;

  // compression / encryption method codes carried in the method byte
  localparam logic [7:0] METHOD_NONE   = 8'd0;
  localparam logic [7:0] METHOD_ZLIB   = 8'd1;
  localparam logic [7:0] METHOD_LZMA   = 8'd2;
  localparam logic [7:0] METHOD_FERNET = 8'd3;

  logic               clk;
  logic               rst;
  logic               byte_valid;
  logic               byte_ready;
  aed_pkg::in_beat_t  byte_beat;
  logic               result_valid;
  logic               result_ready;
  aed_pkg::out_beat_t result_beat;

  archive_entry_deframer_top uut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_beat    (byte_beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_beat  (result_beat)
  );

  // parser shadow state
  aed_pkg::phase_t cur_phase;
  logic [63:0]     field_left;
  logic [63:0]     field_value;
  logic [63:0]     entry_orig_size;
  logic            order_big;
  logic            magic_bad;

  aed_pkg::out_beat_t expected_results[$];
  logic [7:0]         archive_bytes[$];
  aed_pkg::out_beat_t want;
  logic               no_idle = 1'b0;
  int                 fails = 0;
  int                 beats_sent = 0;
  int                 archives_sent = 0;
  int                 results_checked = 0;
  int                 quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // parser prediction
  // ---------------------------------------------------------------------------

  function automatic void parser_clear();
    cur_phase       = aed_pkg::PH_MAGIC;
    field_left      = 64'd4;
    field_value     = '0;
    entry_orig_size = '0;
    order_big       = 1'b1;
    magic_bad       = 1'b0;
  endfunction

  function automatic void open_field(aed_pkg::phase_t ph, logic [63:0] count);
    cur_phase   = ph;
    field_left  = count;
    field_value = '0;
  endfunction

  // multi-byte fields follow the byte order latched from the magic word
  function automatic void shift_in(logic [7:0] b, int width);
    if (order_big) begin
      field_value = {field_value[55:0], b};
    end else begin
      field_value = (field_value >> 8) | ({56'd0, b} << (8 * (width - 1)));
    end
  endfunction

  function automatic void expect_result(logic [2:0] kind, logic [7:0] value,
                                        logic [63:0] orig, logic [63:0] proc,
                                        logic [1:0] method, logic [2:0] err);
    aed_pkg::out_beat_t r;
    r                = '0;
    r.result_kind    = kind;
    r.byte_value     = value;
    r.original_size  = orig;
    r.processed_size = proc;
    r.method_code    = method;
    r.error_code     = err;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_beat(aed_pkg::in_beat_t beat);
    int                 first;
    logic               closing;
    logic [2:0]         status;
    aed_pkg::out_beat_t r;
    first   = expected_results.size();
    closing = (field_left <= 64'd1);
    case (cur_phase)
      aed_pkg::PH_MAGIC: begin
        field_value = {32'd0, field_value[23:0], beat.data_byte};
        if (closing) cur_phase = aed_pkg::PH_VERSION;
        else field_left--;
      end
      aed_pkg::PH_VERSION: begin
        // magic is judged when the version byte shows up
        if (field_value[31:0] == aed_pkg::MAGIC_WORD ||
            field_value[31:0] == aed_pkg::MAGIC_SWAP) begin
          order_big = (field_value[31:0] == aed_pkg::MAGIC_WORD);
          expect_result(aed_pkg::KIND_HEADER, beat.data_byte, '0, '0, '0,
                        aed_pkg::ERR_NONE);
          open_field(aed_pkg::PH_NAMELEN, 64'd4);
        end else begin
          magic_bad = 1'b1;
          cur_phase = aed_pkg::PH_SKIP;
        end
      end
      aed_pkg::PH_NAMELEN: begin
        shift_in(beat.data_byte, 4);
        if (!closing) field_left--;
        else if (field_value == '0) open_field(aed_pkg::PH_ORIG, 64'd8);
        else open_field(aed_pkg::PH_NAME, field_value);
      end
      aed_pkg::PH_NAME: begin
        expect_result(aed_pkg::KIND_NAME, beat.data_byte, '0, '0, '0, aed_pkg::ERR_NONE);
        if (closing) open_field(aed_pkg::PH_ORIG, 64'd8);
        else field_left--;
      end
      aed_pkg::PH_ORIG: begin
        shift_in(beat.data_byte, 8);
        if (!closing) begin
          field_left--;
        end else begin
          entry_orig_size = field_value;
          open_field(aed_pkg::PH_PROC, 64'd8);
        end
      end
      aed_pkg::PH_PROC: begin
        shift_in(beat.data_byte, 8);
        if (!closing) begin
          field_left--;
        end else begin
          cur_phase  = aed_pkg::PH_METHOD;
          field_left = 64'd1;
        end
      end
      aed_pkg::PH_METHOD: begin
        if (beat.data_byte > aed_pkg::METHOD_LAST) begin
          // unknown method: no payload, next byte opens a new entry
          expect_result(aed_pkg::KIND_ERROR, '0, '0, '0, '0, aed_pkg::ERR_METHOD);
          open_field(aed_pkg::PH_NAMELEN, 64'd4);
        end else begin
          expect_result(aed_pkg::KIND_METADATA, '0, entry_orig_size, field_value,
                        beat.data_byte[1:0], aed_pkg::ERR_NONE);
          if (field_value == '0) open_field(aed_pkg::PH_NAMELEN, 64'd4);
          else open_field(aed_pkg::PH_PAYLOAD, field_value);
        end
      end
      aed_pkg::PH_PAYLOAD: begin
        expect_result(aed_pkg::KIND_PAYLOAD, beat.data_byte, '0, '0, '0,
                      aed_pkg::ERR_NONE);
        if (closing) open_field(aed_pkg::PH_NAMELEN, 64'd4);
        else field_left--;
      end
      default: begin
      end
    endcase
    if (beat.final_byte) begin
      if (cur_phase == aed_pkg::PH_MAGIC || cur_phase == aed_pkg::PH_VERSION) begin
        status = aed_pkg::ERR_SMALL;
      end else if (magic_bad || cur_phase > aed_pkg::PH_PAYLOAD) begin
        status = aed_pkg::ERR_MAGIC;
      end else if (cur_phase == aed_pkg::PH_NAMELEN && field_left == 64'd4) begin
        status = aed_pkg::ERR_NONE;
      end else begin
        status = aed_pkg::ERR_TRUNCATED;
      end
      expect_result(aed_pkg::KIND_END, '0, '0, '0, '0, status);
      parser_clear();
    end
    // flag the last beat this byte produced
    if (expected_results.size() > first) begin
      r = expected_results.pop_back();
      r.run_last = 1'b1;
      expected_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // archive building
  // ---------------------------------------------------------------------------

  function automatic void add_field(logic [63:0] value, int nbytes, logic big);
    logic [63:0] part;
    for (int k = 0; k < nbytes; k++) begin
      part = value >> (8 * (big ? nbytes - 1 - k : k));
      archive_bytes.push_back(part[7:0]);
    end
  endfunction

  function automatic void add_random(int count);
    for (int k = 0; k < count; k++) archive_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_header(logic big, logic [7:0] version);
    add_field({32'd0, aed_pkg::MAGIC_WORD}, 4, big);
    archive_bytes.push_back(version);
  endfunction

  // complete entry; payload only follows a known method
  function automatic void add_entry(logic big, logic [31:0] name_bytes, logic [63:0] orig,
                                    logic [63:0] proc, logic [7:0] method);
    add_field({32'd0, name_bytes}, 4, big);
    add_random(int'(name_bytes));
    add_field(orig, 8, big);
    add_field(proc, 8, big);
    archive_bytes.push_back(method);
    if (method <= aed_pkg::METHOD_LAST) add_random(int'(proc));
  endfunction

  function automatic logic [63:0] random_size();
    logic [63:0] v;
    case ($urandom_range(0, 3))
      0:       v = '0;
      1:       v = '1;
      default: v = {32'($urandom), 32'($urandom)};
    endcase
    return v;
  endfunction

  function automatic void build_random_archive();
    logic        big;
    int          pick;
    int          entries;
    int          idx;
    int          cut;
    logic [31:0] name_bytes;
    logic [63:0] proc;
    logic [7:0]  method;
    big  = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    // plain noise, almost never a valid magic
    if (pick < 12) begin
      add_random($urandom_range(1, 24));
      return;
    end
    add_header(big, 8'($urandom_range(0, 255)));
    if (pick < 18) begin
      idx = $urandom_range(0, 3);
      archive_bytes[idx] = archive_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
    end
    entries = $urandom_range(0, 4);
    for (int e = 0; e < entries; e++) begin
      if ($urandom_range(0, 19) == 0) begin
        // oversized name or payload, archive gets cut inside it
        if ($urandom_range(0, 1) == 1) begin
          add_field({32'd0, 32'($urandom) | 32'h0001_0000}, 4, big);
        end else begin
          add_field('0, 4, big);
          add_field(random_size(), 8, big);
          add_field({32'($urandom) | 32'h8000_0000, 32'($urandom)}, 8, big);
          archive_bytes.push_back(8'($urandom_range(0, 3)));
        end
        add_random($urandom_range(0, 8));
        break;
      end
      name_bytes = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 5));
      proc       = 64'($urandom_range(0, 6));
      method     = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(4, 255))
                                               : 8'($urandom_range(0, 3));
      add_entry(big, name_bytes, random_size(), proc, method);
    end
    // early final byte somewhere in the stream
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, archive_bytes.size());
      while (archive_bytes.size() > cut) void'(archive_bytes.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // byte channel driver
  // ---------------------------------------------------------------------------

  // valid is left high after a beat so back-to-back beats never glitch it
  task automatic send_beat(aed_pkg::in_beat_t beat);
    logic taken;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_beat  <= beat;
    // handshake sampled mid-cycle, where nothing moves until the next edge
    do begin
      @(negedge clk);
      taken = byte_ready;
      if (taken) predict_beat(beat);
      @(posedge clk);
    end while (!taken);
    beats_sent++;
  endtask

  task automatic send_archive();
    aed_pkg::in_beat_t beat;
    for (int i = 0; i < archive_bytes.size(); i++) begin
      beat.data_byte  = archive_bytes[i];
      beat.final_byte = (i == archive_bytes.size() - 1);
      send_beat(beat);
    end
    archive_bytes.delete();
    archives_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // result channel: random back-pressure, off in the quiet phase
  // ---------------------------------------------------------------------------

  initial begin
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      result_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // result beats compared in order against the predicted stream
  always @(negedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat kind=%0d byte=%02h err=%0d last=%0b",
                 $time, result_beat.result_kind, result_beat.byte_value,
                 result_beat.error_code, result_beat.run_last);
        fails++;
      end else begin
        want = expected_results.pop_front();
        if (result_beat !== want) begin
          $display("%0t: result mismatch expected kind=%0d byte=%02h orig=%016h proc=%016h",
                   $time, want.result_kind, want.byte_value, want.original_size,
                   want.processed_size);
          $display("    method=%0d err=%0d last=%0b, actual kind=%0d byte=%02h orig=%016h",
                   want.method_code, want.error_code, want.run_last,
                   result_beat.result_kind, result_beat.byte_value,
                   result_beat.original_size);
          $display("    proc=%016h method=%0d err=%0d last=%0b",
                   result_beat.processed_size, result_beat.method_code,
                   result_beat.error_code, result_beat.run_last);
          fails++;
        end
        results_checked++;
      end
    end
  end

  // watchdog on cycles with no beat moving on either channel
  always @(negedge clk) begin
    if (rst || (byte_valid && byte_ready) || (result_valid && result_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_results.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // archives that end in or right after the header
  task automatic test_header_cases();
    // final on the first byte: too small
    archive_bytes.push_back(8'h41);
    send_archive();
    // full magic but no version: too small
    add_field({32'd0, aed_pkg::MAGIC_WORD}, 4, 1'b1);
    send_archive();
    // bad magic cut before the version still counts as too small
    add_field('0, 4, 1'b1);
    send_archive();
    // bad magic, version and trailing junk all ignored
    add_field('1, 4, 1'b1);
    archive_bytes.push_back(8'h00);
    add_random(3);
    send_archive();
    // header only, both byte orders, version extremes
    add_header(1'b1, 8'h00);
    send_archive();
    add_header(1'b0, 8'hFF);
    send_archive();
  endtask

  // well-formed entries, every method, unknown methods and truncation
  task automatic test_entry_cases();
    add_header(1'b1, 8'h01);
    add_entry(1'b1, 32'd2, '1, 64'd3, METHOD_NONE);
    add_entry(1'b1, 32'd0, '0, 64'd0, METHOD_ZLIB);
    add_entry(1'b1, 32'd1, 64'h0123_4567_89AB_CDEF, 64'd1, 8'h04);
    add_entry(1'b1, 32'd0, '0, 64'd2, 8'hFF);
    add_entry(1'b1, 32'd0, '0, 64'd2, METHOD_FERNET);
    add_entry(1'b1, 32'd1, 64'd1, 64'd1, METHOD_LZMA);
    send_archive();
    // little-endian, closes on a zero-size entry's method byte
    add_header(1'b0, 8'h7F);
    add_entry(1'b0, 32'd3, random_size(), 64'd2, METHOD_FERNET);
    add_entry(1'b0, 32'd0, 64'h8000_0000_0000_0001, 64'd0, METHOD_NONE);
    send_archive();
    // final byte is an unknown method
    add_header(1'b0, 8'h10);
    add_entry(1'b0, 32'd1, '0, 64'd0, 8'h80);
    send_archive();
    // huge name length, cut inside the name
    add_header(1'b1, 8'h02);
    add_field({32'd0, 32'hFFFF_FFFF}, 4, 1'b1);
    add_random(3);
    send_archive();
    // huge payload size, cut inside the payload
    add_header(1'b0, 8'h03);
    add_field('0, 4, 1'b0);
    add_field('0, 8, 1'b0);
    add_field('1, 8, 1'b0);
    archive_bytes.push_back(METHOD_NONE);
    add_random(2);
    send_archive();
    // cut inside a name length field
    add_header(1'b1, 8'h04);
    add_random(2);
    send_archive();
  endtask

  task automatic test_random_archives(int target, logic quiet);
    int stop_at;
    no_idle = quiet;
    stop_at = beats_sent + target;
    while (beats_sent < stop_at) begin
      build_random_archive();
      send_archive();
    end
  endtask

  initial begin
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    byte_beat  <= '0;
    parser_clear();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_header_cases();
    test_entry_cases();
    test_random_archives(NOISY_BEATS, 1'b0);
    // closing stretch runs with both sides at full rate
    test_random_archives(QUIET_BEATS, 1'b1);
    byte_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d archives in %0d byte beats, %0d result beats checked",
             archives_sent, beats_sent, results_checked);
    $display("both byte orders, all methods, bad magic, short and truncated archives");
    if (fails == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
